@@ rtl/tbpc_pkg.sv @@
package tbpc_pkg;

  localparam logic [7:0] LONG_PRESS_RESET = 8'd100;

  // Bit positions of the two buttons in the stable level vector
  localparam logic [1:0] MODE_BIT = 2'b01;
  localparam logic [1:0] FUNC_BIT = 2'b10;
  localparam logic [1:0] BOTH_BITS = 2'b11;

  typedef struct packed {
    logic sample_valid;
    logic mode_pressed;
    logic func_pressed;
  } tbpc_in_t;

  typedef struct packed {
    logic mode_short;
    logic func_short;
    logic mode_long;
    logic func_long;
    logic combo_held;
    logic any_held;
  } tbpc_out_t;

endpackage

@@ rtl/tbpc_in_stage.sv @@
module tbpc_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tbpc_pkg::tbpc_in_t in_data,
  input  logic               take,
  output logic               full,
  output tbpc_pkg::tbpc_in_t item
);
  import tbpc_pkg::*;

  logic load;

  assign in_stall = full && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_data;
    end
  end

endmodule

@@ rtl/tbpc_core.sv @@
module tbpc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                step,
  input  tbpc_pkg::tbpc_in_t  item,
  output tbpc_pkg::tbpc_out_t result
);
  import tbpc_pkg::*;

  logic [7:0] long_press_ticks;
  logic [1:0] stable_levels, stable_levels_next;
  logic       change_pending, change_pending_next;
  logic       mode_held_flag, mode_held_flag_next;
  logic       func_held_flag, func_held_flag_next;
  logic       combo_flag, combo_flag_next;
  logic       timing_flag, timing_flag_next;
  logic [7:0] hold_ticks, hold_ticks_next;
  logic [1:0] raw;
  logic [1:0] diff;
  logic       m_short, f_short, m_long, f_long;

  assign raw  = {item.func_pressed, item.mode_pressed};
  assign diff = raw ^ stable_levels;

  always_comb begin
    stable_levels_next  = stable_levels;
    change_pending_next = change_pending;
    mode_held_flag_next = mode_held_flag;
    func_held_flag_next = func_held_flag;
    combo_flag_next     = combo_flag;
    timing_flag_next    = timing_flag;
    hold_ticks_next     = hold_ticks;
    m_short = 1'b0;
    f_short = 1'b0;
    m_long  = 1'b0;
    f_long  = 1'b0;

    if (item.sample_valid) begin
      if (raw != stable_levels) begin
        hold_ticks_next = '0;
        if (change_pending) begin
          change_pending_next = 1'b0;
          stable_levels_next  = raw;
          case (diff)
            MODE_BIT: begin
              if (raw[0]) begin
                mode_held_flag_next = 1'b1;
                if (func_held_flag) begin
                  combo_flag_next = 1'b1;
                end
                timing_flag_next = 1'b1;
              end else begin
                m_short             = mode_held_flag;
                mode_held_flag_next = 1'b0;
                combo_flag_next     = 1'b0;
                timing_flag_next    = 1'b0;
              end
            end
            FUNC_BIT: begin
              if (raw[1]) begin
                func_held_flag_next = 1'b1;
                if (mode_held_flag) begin
                  combo_flag_next = 1'b1;
                end
                timing_flag_next = 1'b1;
              end else begin
                f_short             = func_held_flag;
                func_held_flag_next = 1'b0;
                combo_flag_next     = 1'b0;
                timing_flag_next    = 1'b0;
              end
            end
            default: begin
              // both levels moved together
              if (raw == BOTH_BITS) begin
                combo_flag_next  = 1'b1;
                timing_flag_next = 1'b1;
              end else begin
                combo_flag_next     = 1'b0;
                mode_held_flag_next = 1'b0;
                func_held_flag_next = 1'b0;
                timing_flag_next    = 1'b0;
              end
            end
          endcase
        end else begin
          change_pending_next = 1'b1;
        end
      end else begin
        change_pending_next = 1'b0;
      end

      // timer runs after the change handling of the same tick
      if (timing_flag_next) begin
        hold_ticks_next = hold_ticks_next + 8'd1;
        if (hold_ticks_next >= long_press_ticks) begin
          hold_ticks_next  = '0;
          timing_flag_next = 1'b0;
          if (mode_held_flag_next) begin
            mode_held_flag_next = 1'b0;
            m_long = 1'b1;
          end else if (func_held_flag_next) begin
            func_held_flag_next = 1'b0;
            f_long = 1'b1;
          end
        end
      end else begin
        hold_ticks_next = '0;
      end
    end
  end

  assign result.mode_short = m_short;
  assign result.func_short = f_short;
  assign result.mode_long  = m_long;
  assign result.func_long  = f_long;
  assign result.combo_held = combo_flag_next;
  assign result.any_held   = timing_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      long_press_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_levels  <= '0;
      change_pending <= 1'b0;
      mode_held_flag <= 1'b0;
      func_held_flag <= 1'b0;
      combo_flag     <= 1'b0;
      timing_flag    <= 1'b0;
      hold_ticks     <= '0;
    end else if (step) begin
      stable_levels  <= stable_levels_next;
      change_pending <= change_pending_next;
      mode_held_flag <= mode_held_flag_next;
      func_held_flag <= func_held_flag_next;
      combo_flag     <= combo_flag_next;
      timing_flag    <= timing_flag_next;
      hold_ticks     <= hold_ticks_next;
    end
  end

endmodule

@@ rtl/tbpc_out_stage.sv @@
module tbpc_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  tbpc_pkg::tbpc_out_t result,
  output logic                ready,
  output logic                out_valid,
  input  logic                out_stall,
  output tbpc_pkg::tbpc_out_t out_data
);
  import tbpc_pkg::*;

  // a new result may enter while the held one leaves in the same cycle
  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

endmodule

@@ rtl/two_button_press_classifier.sv @@
// Channel | Direction | Handshake             | Payload
// input   | in        | in_valid / in_stall   | in_data  (tbpc_in_t)
// output  | out       | out_valid / out_stall | out_data (tbpc_out_t)
// config  | in        | cfg_we                | cfg_wdata (long_press_ticks)
//
// One transaction per clock cycle sustained while out_stall is low; an accepted input
// passes the input register, then the result register, before it is valid at out_data.
// The classifier state is updated as an item moves into the result register.
// Synchronous reset clears both stages and all press state; limit returns to 100.
// An output stall backs up through the result register to in_stall.
module two_button_press_classifier (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tbpc_pkg::tbpc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tbpc_pkg::tbpc_out_t out_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  import tbpc_pkg::*;

  logic      in_full;
  logic      out_ready;
  logic      step;
  tbpc_in_t  item;
  tbpc_out_t result;

  assign step = in_full && out_ready;

  tbpc_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take     (step),
    .full     (in_full),
    .item     (item)
  );

  tbpc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .result    (result)
  );

  tbpc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .result    (result),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/tbpc_checker.sv @@
module tbpc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tbpc_pkg::tbpc_out_t out_data
);
  import tbpc_pkg::*;

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not empty after reset");

  // input can only back up behind a waiting result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_one_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({out_data.mode_short, out_data.func_short,
                              out_data.mode_long, out_data.func_long}) <= 1)
    else $error("more than one press event in a result");

  // a long press ends the timing
  a_long_ends_timing: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.mode_long || out_data.func_long) |-> !out_data.any_held)
    else $error("long press with timing still running");

endmodule

bind two_button_press_classifier tbpc_checker u_tbpc_checker (.*);
